// ===== rtl/core/swb_pkg.sv =====
// Package with shared constants and codes for the subtract-with-borrow generator.
package swb_pkg;

    localparam int SWB_SHORT_LAG = 10;
    localparam int SWB_LONG_LAG  = 24;
    localparam int SWB_WORD_BITS = 24;

    localparam int FRAC_BITS    = 24;
    localparam int SEED_BITS    = 24;
    localparam int WARMUP_BITS  = 16;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;

    localparam logic [WARMUP_BITS-1:0] WARMUP_RESET = 16'd2000;

    typedef enum logic [0:0] {
        OP_NEXT = 1'b0,
        OP_SEED = 1'b1
    } opcode_t;

    typedef enum logic [0:0] {
        REG_WARMUP_COUNT = 1'b0
    } reg_index_t;

endpackage

// ===== rtl/core/swb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module swb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 24
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/subtract_with_borrow_rng.sv =====
// Top level of the lagged subtract-with-borrow random generator.
// A next transaction's result is written into the output register when the transaction is accepted.
// Throughput: one next transaction per cycle while in_stall is low, set by the read-modify-write of the lag RAMs.
// A seed transaction is followed by warmup_count discarded steps, one per cycle, while the input stalls.
// Reset clears the borrow, the write pointer and the valid bits, so the store reads as zero.
// No clearing pass runs after reset; warmup_count resets to 2000.
module subtract_with_borrow_rng #(
    parameter int SHORT_LAG = swb_pkg::SWB_SHORT_LAG,
    parameter int LONG_LAG  = swb_pkg::SWB_LONG_LAG,
    parameter int WORD_BITS = swb_pkg::SWB_WORD_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 opcode,
    input  logic [swb_pkg::SEED_BITS-1:0]        seed_value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [swb_pkg::FRAC_BITS-1:0]        random_fraction,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [swb_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [swb_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [swb_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                 pready
);

    localparam int PTR_W = $clog2(LONG_LAG);
    localparam logic [PTR_W:0]   LAG_EXT   = (PTR_W+1)'(LONG_LAG);
    localparam logic [PTR_W:0]   SHORT_OFF = (PTR_W+1)'(LONG_LAG - SHORT_LAG);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(LONG_LAG - 1);

    logic [swb_pkg::WARMUP_BITS-1:0] warmup_count_reg;
    logic [swb_pkg::WARMUP_BITS-1:0] warm_left_reg, warm_left_next;
    logic [WORD_BITS-1:0]            fill_reg;
    logic [LONG_LAG-1:0]             valid_reg;
    logic [PTR_W-1:0]                wp_reg, wp_next;
    logic                            borrow_reg;
    logic                            fwd_a_reg, fwd_b_reg;
    logic                            valid_a_reg, valid_b_reg;
    logic [WORD_BITS-1:0]            fwd_word_reg;
    logic                            out_valid_reg;
    logic [swb_pkg::FRAC_BITS-1:0]   frac_reg;

    logic                            cfg_write;
    logic                            warm_busy;
    logic                            out_blocked;
    logic                            in_accept;
    logic                            next_acc;
    logic                            seed_acc;
    logic                            step;
    logic [PTR_W-1:0]                rd_a_addr, rd_b_addr;
    logic [PTR_W:0]                  short_sum;
    logic [WORD_BITS-1:0]            q_a, q_b;
    logic [WORD_BITS-1:0]            op_a, op_b;
    logic [WORD_BITS:0]              diff;
    logic [WORD_BITS-1:0]            word;
    logic [WORD_BITS+31:0]           frac_ext;
    logic [WORD_BITS+31:0]           frac_shift;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == swb_pkg::REG_WARMUP_COUNT)
        begin
            prdata = swb_pkg::CFG_DATA_W'(warmup_count_reg);
        end
    end

    assign warm_busy   = (warm_left_reg != '0);
    assign out_blocked = out_valid_reg && out_stall;
    assign in_stall    = warm_busy || out_blocked;
    assign in_accept   = in_valid && !in_stall;
    assign next_acc    = in_accept && (opcode == swb_pkg::OP_NEXT);
    assign seed_acc    = in_accept && (opcode == swb_pkg::OP_SEED);
    assign step        = next_acc || warm_busy;

    always_comb
    begin
        if (step)
        begin
            wp_next = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
        end
        else
        begin
            wp_next = wp_reg;
        end
        short_sum = {1'b0, wp_next} + SHORT_OFF;
        if (short_sum >= LAG_EXT)
        begin
            short_sum = short_sum - LAG_EXT;
        end
        rd_a_addr = short_sum[PTR_W-1:0];
        rd_b_addr = wp_next;
    end

    always_comb
    begin
        if (fwd_a_reg)
        begin
            op_a = fwd_word_reg;
        end
        else
        begin
            op_a = valid_a_reg ? q_a : fill_reg;
        end
        if (fwd_b_reg)
        begin
            op_b = fwd_word_reg;
        end
        else
        begin
            op_b = valid_b_reg ? q_b : fill_reg;
        end
        diff       = {1'b0, op_a} - {1'b0, op_b} - (WORD_BITS+1)'(borrow_reg);
        word       = diff[WORD_BITS-1:0];
        frac_ext   = {word, 32'd0};
        frac_shift = frac_ext >> (WORD_BITS + 8);
    end

    always_comb
    begin
        warm_left_next = warm_left_reg;
        if (seed_acc)
        begin
            warm_left_next = warmup_count_reg;
        end
        else if (warm_busy)
        begin
            warm_left_next = warm_left_reg - 1'b1;
        end
    end

    swb_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(LONG_LAG)
    ) u_ram_short (
        .clk  (clk),
        .we   (step),
        .waddr(wp_reg),
        .wdata(word),
        .raddr(rd_a_addr),
        .rdata(q_a)
    );

    swb_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(LONG_LAG)
    ) u_ram_long (
        .clk  (clk),
        .we   (step),
        .waddr(wp_reg),
        .wdata(word),
        .raddr(rd_b_addr),
        .rdata(q_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warmup_count_reg <= swb_pkg::WARMUP_RESET;
            warm_left_reg    <= '0;
            fill_reg         <= '0;
            valid_reg        <= '0;
            wp_reg           <= '0;
            borrow_reg       <= 1'b0;
            fwd_a_reg        <= 1'b0;
            fwd_b_reg        <= 1'b0;
            valid_a_reg      <= 1'b0;
            valid_b_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write && (paddr[2] == swb_pkg::REG_WARMUP_COUNT))
            begin
                warmup_count_reg <= pwdata[swb_pkg::WARMUP_BITS-1:0];
            end
            warm_left_reg <= warm_left_next;
            wp_reg        <= wp_next;
            fwd_a_reg     <= step && (rd_a_addr == wp_reg);
            fwd_b_reg     <= step && (rd_b_addr == wp_reg);
            valid_a_reg   <= valid_reg[rd_a_addr] && !seed_acc;
            valid_b_reg   <= valid_reg[rd_b_addr] && !seed_acc;
            if (seed_acc)
            begin
                fill_reg  <= WORD_BITS'(seed_value);
                valid_reg <= '0;
            end
            else if (step)
            begin
                valid_reg[wp_reg] <= 1'b1;
            end
            if (step)
            begin
                borrow_reg <= diff[WORD_BITS];
            end
            if (next_acc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            fwd_word_reg <= word;
        end
        if (next_acc)
        begin
            frac_reg <= frac_shift[swb_pkg::FRAC_BITS-1:0];
        end
    end

    assign out_valid       = out_valid_reg;
    assign random_fraction = frac_reg;

    a_warm_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        warm_busy |-> in_stall)
        else $error("input not stalled during warm-up");

    a_out_from_next: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(next_acc))
        else $error("result appeared without a next transaction");

    a_seed_loads_count: assert property (@(posedge clk) disable iff (!rst_n)
        seed_acc |=> (warm_left_reg == $past(warmup_count_reg)))
        else $error("warm-up counter not loaded on seed");

    a_ptr_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(wp_reg))
        else $error("write pointer moved without a generator step");

    a_no_step_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_blocked && !warm_busy) |-> !step)
        else $error("generator stepped while the result was stalled");

endmodule
